[hdl/sem_pkg.sv]
// Package for the 3x3 Sobel edge magnitude block: sizes, register indexes, types.
// Depends on nothing; the top level imports it.
`default_nettype none
package sem_pkg;
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int PIX_W  = 8;
    localparam int FW_W   = 12;
    localparam int FH_W   = 16;
    localparam int IDX_W  = 1;
    localparam int DATA_W = 16;
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
    localparam logic [FW_W-1:0] FW_RESET = 12'd640;
    localparam logic [FH_W-1:0] FH_RESET = 16'd480;
    // gx, gy are at most 4*255 = 1020 (10 bits); sum of squares fits 21 bits.
    localparam int G_W   = 10;
    localparam int SQ_W  = 21;
    localparam int RT_W  = 11;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } pix_req_t;

    typedef struct packed {
        logic [PIX_W-1:0] magnitude;
        logic             frame_last;
    } mag_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] data;
    } cfg_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_ROOT,
        ST_SEND
    } sem_state_t;
endpackage
`default_nettype wire

[hdl/sem_if.sv]
// Valid/ready channel interface carrying one request payload.
// Depends on nothing; the payload type is a parameter.
`default_nettype none
interface sem_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/sobel_edge_magnitude_3x3.sv]
// Top level of the 3x3 Sobel edge magnitude block with its line stores.
// Depends on sem_pkg and sem_if.
//
// Pixels enter in raster order and are accepted only in the idle state. The
// accept registers the line-store word, and the READ state then forms the
// gradient sums. At interior positions an 11-step integer square root loop and
// the result slot follow; the result slot holds until ready. Border positions
// give no result and return to idle from READ. No new pixel is taken before
// the last one is through.
// The two line stores are one synchronous memory of 16-bit words (upper and
// middle rows side by side) read and written back at the column address; a
// new pixel is taken only after the prior write-back; no forwarding is needed.
// The line stores need no clearing: no result reads an unwritten entry.
`default_nettype none
module sobel_edge_magnitude_3x3
#(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
)
(
    input wire logic clk,
    input wire logic rst_n,
    sem_if.sink      pix_in,
    sem_if.source    mag_out,
    sem_if.sink      cfg
);
    import sem_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);

    // Configuration registers.
    logic [FW_W-1:0] fw_reg;
    logic [FH_W-1:0] fh_reg;
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FW_RESET;
            fh_reg <= FH_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                REG_FRAME_WIDTH:  fw_reg <= cfg.data.data[FW_W-1:0];
                REG_FRAME_HEIGHT: fh_reg <= cfg.data.data;
                default: ;
            endcase
        end
    end

    // Effective sizes minus one.
    logic [CW-1:0] wm1;
    logic [FH_W-1:0] hm1;
    always_comb
    begin
        if ({4'd0, fw_reg} < 16'd3)
            wm1 = CW'(2);
        else if (32'(fw_reg) > MAX_WIDTH)
            wm1 = CW'(MAX_WIDTH - 1);
        else
            wm1 = CW'(32'(fw_reg) - 1);
        hm1 = (fh_reg < 16'd3) ? 16'd2 : fh_reg - 16'd1;
    end

    // Control and datapath registers.
    sem_state_t state_reg, state_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [FH_W-1:0] row_reg, row_next;
    logic [PIX_W-1:0] pix_reg;
    logic [CW-1:0]   ccol_reg;
    logic [FH_W-1:0] crow_reg;
    logic [PIX_W-1:0] l0_reg, l1_reg, l2_reg, c0_reg, c1_reg, c2_reg;
    logic [SQ_W-1:0] v_reg;
    logic [SQ_W-1:0] res_reg;
    logic [SQ_W-1:0] bit_reg;
    logic            last_reg;

    // Line store memory: [15:8] upper row, [7:0] middle row.
    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;
    logic [AW-1:0] addr;
    logic [AW-1:0] addr_reg;
    logic          wr_en;

    logic [CW-1:0] col_eff;
    assign col_eff = pix_in.data.frame_start ? '0 : col_reg;
    always_comb
    begin
        if (32'(col_eff) >= MAX_WIDTH)
            addr = AW'(MAX_WIDTH - 1);
        else
            addr = col_eff[AW-1:0];
    end

    logic accept;
    assign pix_in.ready = (state_reg == ST_IDLE);
    assign accept = pix_in.valid && pix_in.ready;

    always_ff @(posedge clk)
    begin
        if (accept)
            rd_reg <= mem[addr];
        if (wr_en)
            mem[addr_reg] <= {rd_reg[PIX_W-1:0], pix_reg};
    end

    // Gradient arithmetic on the read word and window.
    logic [PIX_W-1:0] top, mid, bot;
    logic [G_W-1:0] sr, sl, sb, st, gx, gy;
    logic [SQ_W-1:0] sq;
    assign top = rd_reg[2*PIX_W-1:PIX_W];
    assign mid = rd_reg[PIX_W-1:0];
    assign bot = pix_reg;
    always_comb
    begin
        sr = G_W'(top) + G_W'({mid, 1'b0}) + G_W'(bot);
        sl = G_W'(l0_reg) + G_W'({l1_reg, 1'b0}) + G_W'(l2_reg);
        sb = G_W'(l2_reg) + G_W'({c2_reg, 1'b0}) + G_W'(bot);
        st = G_W'(l0_reg) + G_W'({c0_reg, 1'b0}) + G_W'(top);
        gx = (sr >= sl) ? sr - sl : sl - sr;
        gy = (sb >= st) ? sb - st : st - sb;
        sq = SQ_W'(gx) * SQ_W'(gx) + SQ_W'(gy) * SQ_W'(gy);
    end
    logic interior;
    assign interior = (crow_reg >= 16'd2) && (ccol_reg >= CW'(2));

    // One square root step.
    logic [SQ_W-1:0] trial;
    assign trial = res_reg + bit_reg;

    logic [RT_W-1:0] root_q;
    assign root_q = RT_W'(res_reg >> 2);

    // State register and sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            l0_reg <= '0; l1_reg <= '0; l2_reg <= '0;
            c0_reg <= '0; c1_reg <= '0; c2_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            if (state_reg == ST_READ)
            begin
                l0_reg <= c0_reg; l1_reg <= c1_reg; l2_reg <= c2_reg;
                c0_reg <= top;    c1_reg <= mid;    c2_reg <= bot;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg  <= pix_in.data.pixel;
            addr_reg <= addr;
            ccol_reg <= col_eff;
            crow_reg <= pix_in.data.frame_start ? '0 : row_reg;
        end
        if (state_reg == ST_READ)
        begin
            v_reg    <= sq;
            res_reg  <= '0;
            bit_reg  <= SQ_W'(1) << (SQ_W - 1);
            last_reg <= (crow_reg >= hm1) && (ccol_reg >= wm1);
        end
        else if (state_reg == ST_ROOT)
        begin
            bit_reg <= bit_reg >> 2;
            if (v_reg >= trial)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
        end
    end

    // Final step's result is taken after the loop ends (bit reaches zero).
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        wr_en      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                    if (pix_in.data.frame_start)
                        row_next = '0;
                    if (col_eff >= wm1)
                    begin
                        col_next = '0;
                        if ((pix_in.data.frame_start ? '0 : row_reg) >= hm1)
                            row_next = '0;
                        else
                            row_next = (pix_in.data.frame_start ? '0 : row_reg) + 16'd1;
                    end
                    else
                        col_next = col_eff + CW'(1);
                end
            end
            ST_READ:
            begin
                wr_en = 1'b1;
                state_next = interior ? ST_ROOT : ST_IDLE;
            end
            ST_ROOT:
            begin
                if (bit_reg < SQ_W'(4))
                    state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (mag_out.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // bit starts at 2^20 and is divided by 4 each step; the last step has bit = 1.
    // In SEND the root register holds the finished root and stays unchanged.
    logic [PIX_W-1:0] out_mag;
    assign out_mag = (root_q > RT_W'(255)) ? 8'hFF : root_q[PIX_W-1:0];
    assign mag_out.valid = (state_reg == ST_SEND);
    assign mag_out.data.magnitude  = out_mag;
    assign mag_out.data.frame_last = last_reg;
endmodule
`default_nettype wire
